FILE: rtl/fsk_pkg.sv
// Shared types, constants and functions of the FSK radio packet engine.
package fsk_pkg;

  localparam int unsigned MaxPayload = 66;
  localparam int unsigned BufBytes   = MaxPayload + 5;
  localparam int unsigned BufAw      = $clog2(BufBytes);

  localparam logic [2:0] CmdEvent = 3'd0;
  localparam logic [2:0] CmdRecv  = 3'd1;
  localparam logic [2:0] CmdSend  = 3'd2;
  localparam logic [2:0] CmdLoad  = 3'd3;
  localparam logic [2:0] CmdRead  = 3'd4;

  localparam logic [1:0] RegNode  = 2'd0;
  localparam logic [1:0] RegGroup = 2'd1;
  localparam logic [1:0] RegFixed = 2'd2;
  localparam logic [1:0] RegStep  = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic       fifo_ready;
    logic       power_on_reset;
    logic       wakeup_fired;
    logic       fifo_overflow;
    logic       signal_above;
    logic [7:0] data_byte;
    logic [7:0] header;
    logic [6:0] payload_length;
    logic [6:0] buffer_index;
  } in_item_t;

  typedef struct packed {
    logic        word_valid;
    logic [15:0] radio_word;
    logic        last;
    logic        receive_complete;
    logic        packet_accepted;
    logic        crc_good;
    logic [3:0]  rssi_level;
    logic        engine_idle;
    logic        wakeup_seen;
    logic        power_on_seen;
    logic [7:0]  read_data;
  } out_item_t;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  nwords;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic        complete;
    logic        accepted;
    logic        good;
    logic [3:0]  rssi;
    logic        idle;
    logic        wake;
    logic        por;
    logic        rd_en;
  } job_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    end
    return x;
  endfunction

endpackage

FILE: rtl/fsk_radio_packet_engine.sv
// Top level of the FSK radio packet engine.
// The engine turns radio FIFO events and host commands into 16-bit radio command
// words: it frames sent packets (preamble, sync, group, header, length, payload,
// CRC-16, tail), stores received bytes, checks length, address and CRC, and steps
// the RSSI threshold tree. Each accepted item gives one to four result
// transfers, one per command word (one if it has none), with the status fields
// repeated on each. The front part takes an item a cycle unless a full job
// register, a RAM read or a pending second write stalls it, and hands a job to
// the back part through that one-entry register. A send data byte waits in the
// front part for its buffer RAM read. A send start and the first byte of a
// receive with a group byte each leave a second buffer write, which holds off
// the next item until it is written. A read result carries the registered RAM
// data, held until it is taken.
module fsk_radio_packet_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fsk_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fsk_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  logic          job_valid, job_ready;
  fsk_pkg::job_t job;
  logic [7:0]    rd_data;

  fsk_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job),
    .rd_data_o(rd_data));

  fsk_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .rd_data_i(rd_data), .out_valid_o, .out_ready_i,
    .out_data_o);
endmodule

FILE: rtl/fsk_ram.sv
// Generic RAM, one write port and one read port, with registered read.
module fsk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 71
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/fsk_front.sv
// Front part: accepts items, runs the packet state machine and builds jobs.
module fsk_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fsk_pkg::in_item_t in_data_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output fsk_pkg::job_t     job_o,
  output logic [7:0]        rd_data_o
);
  localparam logic [3:0] PhIdle = 4'd0, PhRecv = 4'd1, PhPre1 = 4'd2, PhPre2 = 4'd3,
    PhPre3 = 4'd4, PhSyn1 = 4'd5, PhSyn2 = 4'd6, PhData = 4'd7, PhCrc1 = 4'd8,
    PhCrc2 = 4'd9, PhTail = 4'd10, PhDone = 4'd11;
  // Front sub-steps: item in, waiting for a send byte from the RAM.
  localparam logic [1:0] StRun = 2'd0, StWait = 2'd2;
  localparam logic [6:0] Buf7 = 7'(fsk_pkg::BufBytes);
  localparam logic [6:0] Max7 = 7'(fsk_pkg::MaxPayload);

  logic [4:0] node_q;
  logic [7:0] group_q, step_q;
  logic [6:0] fixed_q;
  logic [3:0] phase_q, phase_d;
  logic [6:0] spos_q, spos_d, fill_q, fill_d;
  logic [15:0] crc_q, crc_d, pw_q, pw_d;
  logic [2:0] node3_q, node3_d;
  logic [7:0] dec_q, dec_d;
  logic [7:0] len_q, len_d, hdr_q, hdr_d; // shadow of buffer entries 2 and 1
  logic [1:0] st_q, st_d;
  fsk_pkg::in_item_t item_q;
  logic        we;
  logic [6:0]  waddr;
  logic [7:0]  wdata, rdata;
  logic [6:0]  raddr_sel;
  fsk_pkg::job_t job_d, job_q;
  logic        jv_q;
  logic        take, go;
  fsk_pkg::in_item_t it;
  // The group write on the first byte of a receive and the header write of a
  // send leave a second buffer write pending; it goes out on the following cycle.
  logic        pend_q;
  logic [6:0]  paddr_q;
  logic [7:0]  pdata_q;
  logic        wr_pend;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= 5'd0; group_q <= 8'd212; fixed_q <= 7'd0; step_q <= 8'd7;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fsk_pkg::RegNode:  node_q  <= cfg_data_i[4:0];
        fsk_pkg::RegGroup: group_q <= cfg_data_i;
        fsk_pkg::RegFixed: fixed_q <= cfg_data_i[6:0];
        fsk_pkg::RegStep:  step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Buffer RAM: send data bytes are fetched through the registered read before use.
  fsk_ram #(.Width(8), .Depth(fsk_pkg::BufBytes)) u_buf (
    .clk_i, .we_i(we), .waddr_i(waddr[fsk_pkg::BufAw-1:0]), .wdata_i(wdata),
    .raddr_i(raddr_sel[fsk_pkg::BufAw-1:0]), .rdata_o(rdata));

  // No item is taken while the second buffer write is pending.
  assign in_ready_o = (st_q == StRun) && !pend_q && (!jv_q || job_ready_i);
  assign take = in_valid_i && in_ready_o;
  // Ready events in the data phase need a RAM read first.
  assign it = (st_q == StWait) ? item_q : in_data_i;
  assign go = (st_q == StWait) || (take && !(in_data_i.command == fsk_pkg::CmdEvent &&
              in_data_i.fifo_ready && phase_q == PhData));
  // A read keeps its address on the RAM while its job waits, so the
  // registered read data stays valid until the result is taken.
  assign raddr_sel = take ? ((in_data_i.command == fsk_pkg::CmdRead) ?
                             in_data_i.buffer_index : spos_q) :
                     (jv_q && job_q.rd_en) ? item_q.buffer_index : spos_q;
  assign rd_data_o = rdata;

  always_comb begin
    logic [15:0] w [4];
    logic [2:0] nw;
    logic [7:0] o, stp, plen8;
    logic [6:0] f, pl;
    logic [7:0] h;
    logic endp;
    phase_d = phase_q; spos_d = spos_q; fill_d = fill_q; crc_d = crc_q; pw_d = pw_q;
    node3_d = node3_q; dec_d = dec_q; len_d = len_q; hdr_d = hdr_q; st_d = st_q;
    we = 1'b0; waddr = 7'd0; wdata = 8'd0;
    for (int i = 0; i < 4; i++) w[i] = 16'd0;
    nw = 3'd0; o = 8'hAA; f = fill_q; h = 8'd0; pl = 7'd0; endp = 1'b0;
    plen8 = 8'd0;
    stp = (step_q > 8'd1) ? step_q : 8'd1;
    job_d = '0;
    if (take && !go) st_d = StWait;
    if (go) begin
      st_d = StRun;
      case (it.command)
        fsk_pkg::CmdEvent: begin
          if (it.fifo_ready && phase_q == PhRecv) begin
            // Group byte goes to entry 0 now, and only if the group is set: the
            // next write is then the data byte, through the pending write path.
            if (fill_q == 7'd0 && group_q != 8'd0) begin
              we = 1'b1; waddr = 7'd0; wdata = group_q; f = 7'd1;
            end
            if (f < Buf7) begin
              // Entry 0 group write and data write collide only when the
              // group is written; the data then lands at entry 1 next.
              if (!we) begin
                we = 1'b1; waddr = f; wdata = it.data_byte;
              end
              if (f == 7'd1) hdr_d = it.data_byte;
              if (f == 7'd2) len_d = it.data_byte;
              f = f + 7'd1;
            end
            fill_d = f;
            crc_d = fsk_pkg::crc_step(crc_q, it.data_byte);
            if (node3_q < 3'd3) begin
              if (dec_q == 8'd0) begin
                case (node3_q)
                  3'd0: node3_d = it.signal_above ? 3'd4 : 3'd3;
                  3'd1: node3_d = it.signal_above ? 3'd2 : 3'd0;
                  default: node3_d = it.signal_above ? 3'd6 : 3'd5;
                endcase
                if (node3_d < 3'd3) begin
                  w[nw[1:0]] = 16'h94A0 | {12'd0, node3_d, 1'b1}; nw = nw + 3'd1;
                end
                dec_d = stp - 8'd1;
              end else dec_d = dec_q - 8'd1;
            end
            if (fixed_q != 7'd0) endp = (f >= fixed_q) || (f >= Buf7);
            else endp = ({2'b0, f} >= ({1'b0, len_d} + 9'd5)) || (f >= Buf7);
            if (endp) begin
              pw_d = (pw_q & ~16'h00F0) | 16'h0008;
              w[nw[1:0]] = pw_d; nw = nw + 3'd1;
              phase_d = PhIdle;
              job_d.complete = 1'b1;
              if (fixed_q != 7'd0) job_d.accepted = 1'b1;
              else begin
                job_d.good = (crc_d == 16'd0) && (len_d <= {1'b0, Max7});
                job_d.accepted = !hdr_d[6] || node_q == 5'd31 || hdr_d[4:0] == node_q;
              end
            end
          end else if (it.fifo_ready) begin
            case (phase_q)
              PhPre1, PhPre2, PhPre3: phase_d = phase_q + 4'd1;
              PhSyn1: begin o = 8'h2D; phase_d = PhSyn2; end
              PhSyn2: begin o = group_q; phase_d = PhData; spos_d = 7'd1; end
              PhData: begin
                o = rdata;
                crc_d = fsk_pkg::crc_step(crc_q, o);
                spos_d = spos_q + 7'd1;
                plen8 = (len_q > {1'b0, Max7}) ? {1'b0, Max7} : len_q;
                if ({1'b0, spos_d} >= plen8 + 8'd3) phase_d = PhCrc1;
              end
              PhCrc1: begin o = crc_q[7:0]; phase_d = PhCrc2; end
              PhCrc2: begin o = crc_q[15:8]; phase_d = PhTail; end
              PhTail: phase_d = PhDone;
              PhDone: begin
                pw_d = (pw_q & ~16'h00F0) | 16'h0008;
                w[nw[1:0]] = pw_d; nw = nw + 3'd1; phase_d = PhIdle;
              end
              default: phase_d = PhIdle;
            endcase
            w[nw[1:0]] = {8'hB8, o}; nw = nw + 3'd1;
          end
          if (it.power_on_reset) begin
            job_d.por = 1'b1; phase_d = PhIdle;
          end
          if (it.wakeup_fired) begin
            if (pw_d[1]) begin
              pw_d = pw_d & ~16'h0002;
              w[nw[1:0]] = pw_d; nw = nw + 3'd1;
            end
            job_d.wake = 1'b1;
          end
          if (it.fifo_overflow) begin
            pw_d = (pw_d & ~16'h00F0) | 16'h0008;
            w[nw[1:0]] = pw_d; nw = nw + 3'd1;
            phase_d = PhIdle;
          end
        end
        fsk_pkg::CmdRecv: begin
          fill_d = 7'd0; len_d = 8'd0;
          we = 1'b1; waddr = 7'd2; wdata = 8'd0;
          crc_d = (group_q != 8'd0) ? fsk_pkg::crc_step(16'hFFFF, group_q) : 16'hFFFF;
          phase_d = PhRecv; node3_d = 3'd1;
          dec_d = (group_q != 8'd0 || stp <= 8'd1) ? 8'd0 : 8'd1;
          w[0] = 16'h94A3;
          pw_d = pw_q | 16'h00D8; w[1] = pw_d; nw = 3'd2;
        end
        fsk_pkg::CmdSend: begin
          h = it.header[6] ? it.header : ((it.header & 8'hE0) + {3'd0, node_q});
          hdr_d = h;
          pl = (it.payload_length > Max7) ? Max7 : it.payload_length;
          len_d = {1'b0, pl};
          // Header goes to entry 1 now; length is kept in its shadow and
          // written to entry 2 on the next cycle.
          we = 1'b1; waddr = 7'd1; wdata = h;
          crc_d = fsk_pkg::crc_step(16'hFFFF, group_q);
          phase_d = PhPre1; spos_d = 7'd0;
          pw_d = pw_q | 16'h0038; w[0] = pw_d; nw = 3'd1;
        end
        fsk_pkg::CmdLoad: begin
          if (it.buffer_index < Max7) begin
            we = 1'b1; waddr = it.buffer_index + 7'd3; wdata = it.data_byte;
          end
        end
        fsk_pkg::CmdRead: job_d.rd_en = it.buffer_index < Buf7;
        default: ;
      endcase
      if (nw == 3'd0) job_d.nwords = 3'd0; else job_d.nwords = nw;
      job_d.w0 = w[0]; job_d.w1 = w[1]; job_d.w2 = w[2]; job_d.w3 = w[3];
      job_d.rssi = (node3_d < 3'd3) ? {node3_d, 1'b0} + 4'd2
                   : (4'd8 | {node3_d - 3'd3, 1'b0});
      job_d.idle = phase_d == PhIdle;
    end
    // The pending second write owns the RAM port; no item is taken then.
    if (pend_q) begin
      we = 1'b1; waddr = paddr_q; wdata = pdata_q;
    end
  end

  always_comb begin
    wr_pend = 1'b0;
    if (go && it.command == fsk_pkg::CmdEvent && it.fifo_ready && phase_q == PhRecv &&
        fill_q == 7'd0 && group_q != 8'd0 && fill_d == 7'd2) wr_pend = 1'b1;
    if (go && it.command == fsk_pkg::CmdSend) wr_pend = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; spos_q <= 7'd0; fill_q <= 7'd0; crc_q <= 16'hFFFF;
      pw_q <= 16'h8205; node3_q <= 3'd1; dec_q <= 8'd0; len_q <= 8'd0; hdr_q <= 8'd0;
      st_q <= StRun; jv_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      phase_q <= phase_d; spos_q <= spos_d; fill_q <= fill_d; crc_q <= crc_d;
      pw_q <= pw_d; node3_q <= node3_d; dec_q <= dec_d; len_q <= len_d; hdr_q <= hdr_d;
      st_q <= st_d; pend_q <= wr_pend;
      if (go) jv_q <= 1'b1;
      else if (job_ready_i) jv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= in_data_i;
    if (go) job_q <= job_d;
    if (wr_pend) begin
      if (it.command == fsk_pkg::CmdSend) begin
        paddr_q <= 7'd2; pdata_q <= len_d;
      end else begin
        paddr_q <= 7'd1; pdata_q <= it.data_byte;
      end
    end
  end

  assign job_valid_o = jv_q;
  assign job_o = job_q;
endmodule

FILE: rtl/fsk_back.sv
// Back part: takes jobs, one result per command word or one if none.
module fsk_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  fsk_pkg::job_t      job_i,
  input  logic [7:0]         rd_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fsk_pkg::out_item_t out_data_o
);
  logic [1:0] k_q;
  logic [2:0] n;
  logic [15:0] w;
  logic fin;
  assign n = (job_i.nwords == 3'd0) ? 3'd1 : job_i.nwords;
  always_comb begin
    case (k_q)
      2'd0: w = job_i.w0;
      2'd1: w = job_i.w1;
      2'd2: w = job_i.w2;
      default: w = job_i.w3;
    endcase
  end
  assign fin = ({1'b0, k_q} + 3'd1) == n;
  assign out_valid_o = job_valid_i;
  assign job_ready_o = out_ready_i && fin;
  always_comb begin
    out_data_o.word_valid = job_i.nwords != 3'd0;
    out_data_o.radio_word = (job_i.nwords != 3'd0) ? w : 16'd0;
    out_data_o.last = fin;
    out_data_o.receive_complete = job_i.complete;
    out_data_o.packet_accepted = job_i.accepted;
    out_data_o.crc_good = job_i.good;
    out_data_o.rssi_level = job_i.rssi;
    out_data_o.engine_idle = job_i.idle;
    out_data_o.wakeup_seen = job_i.wake;
    out_data_o.power_on_seen = job_i.por;
    out_data_o.read_data = job_i.rd_en ? rd_data_i : 8'd0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_q <= 2'd0;
    else if (job_valid_i && out_ready_i) k_q <= fin ? 2'd0 : k_q + 2'd1;
  end
endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the FSK radio packet engine.
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [3:0] {
    PhIdle, PhRecv, PhPre1, PhPre2, PhPre3, PhSyn1, PhSyn2,
    PhData, PhCrc1, PhCrc2, PhTail, PhDone
  } phase_e;

  localparam int BufSize = fsk_pkg::BufBytes;
  localparam int PayMax  = fsk_pkg::MaxPayload;
  localparam int IdleLimit = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fsk_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fsk_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  fsk_radio_packet_engine u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #10 clk = ~clk;

  // The engine's state as the predictor sees it.
  logic [4:0]  node_addr = 5'd0;
  logic [7:0]  group_byte = 8'd212;
  logic [6:0]  fixed_len = 7'd0;
  logic [7:0]  rssi_step = 8'd7;
  phase_e      phase = PhIdle;
  int          send_pos = 0;
  int          fill_cnt = 0;
  logic [15:0] crc_acc = 16'hFFFF;
  int          tree_node = 1;
  int          decide_cnt = 0;
  logic [15:0] power_word = 16'h8205;
  logic [7:0]  pkt_buf [BufSize];
  bit          buf_written [BufSize];

  logic [15:0] word_q [$];
  fsk_pkg::out_item_t expected_q [$];

  int errors = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    return x;
  endfunction

  function automatic void emit_word(logic [15:0] w);
    if (word_q.size() < 4) word_q.push_back(w);
  endfunction

  // Radio idling: clear the receiver and transmitter enables, set the crystal bit.
  function automatic void radio_quiet();
    power_word = (power_word & ~16'h00F0) | 16'h0008;
    emit_word(power_word);
  endfunction

  function automatic void store_byte(int idx, logic [7:0] b);
    pkt_buf[idx] = b;
    buf_written[idx] = 1'b1;
  endfunction

  function automatic int sat_len(int n);
    return (n > PayMax) ? PayMax : n;
  endfunction

  // Works out every result that one accepted item causes.
  task automatic predict_item(input fsk_pkg::in_item_t it);
    bit cmpl, acc, good, wk, pr;
    logic [7:0] rd, o, h, len;
    int step, n;
    fsk_pkg::out_item_t r;
    cmpl = 0; acc = 0; good = 0; wk = 0; pr = 0; rd = 8'h00;
    step = (rssi_step > 1) ? rssi_step : 1;
    word_q.delete();
    case (it.command)
      fsk_pkg::CmdEvent: begin
        if (it.fifo_ready && phase == PhRecv) begin
          if (fill_cnt == 0 && group_byte != 0) begin
            store_byte(0, group_byte);
            fill_cnt = 1;
          end
          if (fill_cnt < BufSize) begin
            store_byte(fill_cnt, it.data_byte);
            fill_cnt++;
          end
          crc_acc = crc16_byte(crc_acc, it.data_byte);
          if (tree_node < 3) begin
            if (decide_cnt == 0) begin
              case (tree_node)
                0: tree_node = it.signal_above ? 4 : 3;
                1: tree_node = it.signal_above ? 2 : 0;
                default: tree_node = it.signal_above ? 6 : 5;
              endcase
              if (tree_node < 3) emit_word(16'h94A0 | 16'(tree_node * 2 + 1));
              decide_cnt = step - 1;
            end else begin
              decide_cnt--;
            end
          end
          len = pkt_buf[2];
          if ((fixed_len != 0) ? (fill_cnt >= fixed_len || fill_cnt >= BufSize)
                               : (fill_cnt >= len + 5 || fill_cnt >= BufSize)) begin
            radio_quiet();
            phase = PhIdle;
            cmpl = 1;
            if (fixed_len != 0) begin
              acc = 1;
            end else begin
              h = pkt_buf[1];
              good = (crc_acc == 16'h0000) && (len <= PayMax);
              acc = !h[6] || node_addr == 5'd31 || h[4:0] == node_addr;
            end
          end
        end else if (it.fifo_ready) begin
          o = 8'hAA;
          case (phase)
            PhPre1, PhPre2, PhPre3: phase = phase_e'(phase + 1);
            PhSyn1: begin
              o = 8'h2D;
              phase = PhSyn2;
            end
            PhSyn2: begin
              o = group_byte;
              phase = PhData;
              send_pos = 1;
            end
            PhData: begin
              o = (send_pos < BufSize) ? pkt_buf[send_pos] : 8'h00;
              crc_acc = crc16_byte(crc_acc, o);
              send_pos++;
              if (send_pos >= 3 + sat_len(pkt_buf[2])) phase = PhCrc1;
            end
            PhCrc1: begin
              o = crc_acc[7:0];
              phase = PhCrc2;
            end
            PhCrc2: begin
              o = crc_acc[15:8];
              phase = PhTail;
            end
            PhTail: phase = PhDone;
            PhDone: begin
              radio_quiet();
              phase = PhIdle;
            end
            default: phase = PhIdle;
          endcase
          emit_word(16'hB800 | {8'h00, o});
        end
        if (it.power_on_reset) begin
          pr = 1;
          phase = PhIdle;
        end
        if (it.wakeup_fired) begin
          if (power_word[1]) begin
            power_word[1] = 1'b0;
            emit_word(power_word);
          end
          wk = 1;
        end
        if (it.fifo_overflow) begin
          radio_quiet();
          phase = PhIdle;
        end
      end
      fsk_pkg::CmdRecv: begin
        fill_cnt = 0;
        store_byte(2, 8'h00);
        crc_acc = (group_byte != 0) ? crc16_byte(16'hFFFF, group_byte) : 16'hFFFF;
        phase = PhRecv;
        tree_node = 1;
        decide_cnt = (group_byte != 0 || step <= 1) ? 0 : 1;
        emit_word(16'h94A3);
        power_word = power_word | 16'h00D8;
        emit_word(power_word);
      end
      fsk_pkg::CmdSend: begin
        h = it.header[6] ? it.header : ((it.header & 8'hE0) + {3'd0, node_addr});
        store_byte(1, h);
        store_byte(2, 8'(sat_len(it.payload_length)));
        crc_acc = crc16_byte(16'hFFFF, group_byte);
        phase = PhPre1;
        send_pos = 0;
        power_word = power_word | 16'h0038;
        emit_word(power_word);
      end
      fsk_pkg::CmdLoad: begin
        if (it.buffer_index < PayMax) store_byte(it.buffer_index + 3, it.data_byte);
      end
      fsk_pkg::CmdRead: begin
        if (it.buffer_index < BufSize) rd = pkt_buf[it.buffer_index];
      end
      default: ;
    endcase
    n = (word_q.size() > 0) ? word_q.size() : 1;
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.word_valid = (word_q.size() > 0);
      r.radio_word = (word_q.size() > 0) ? word_q[k] : 16'h0000;
      r.last = (k == n - 1);
      r.receive_complete = cmpl;
      r.packet_accepted = acc;
      r.crc_good = good;
      r.rssi_level = 4'((tree_node < 3) ? (tree_node * 2 + 2) : (8 | ((tree_node - 3) * 2)));
      r.engine_idle = (phase == PhIdle);
      r.wakeup_seen = wk;
      r.power_on_seen = pr;
      r.read_data = rd;
      expected_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] exp);
    errors++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, exp);
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] exp);
    if (got !== exp) report_mismatch(field, got, exp);
  endtask

  // Result checker: every output transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    fsk_pkg::out_item_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.radio_word, 16'h0000);
      end else begin
        exp = expected_q.pop_front();
        check_field("word_valid", 16'(out_data.word_valid), 16'(exp.word_valid));
        check_field("radio_word", out_data.radio_word, exp.radio_word);
        check_field("last", 16'(out_data.last), 16'(exp.last));
        check_field("receive_complete", 16'(out_data.receive_complete),
                    16'(exp.receive_complete));
        check_field("packet_accepted", 16'(out_data.packet_accepted),
                    16'(exp.packet_accepted));
        check_field("crc_good", 16'(out_data.crc_good), 16'(exp.crc_good));
        check_field("rssi_level", 16'(out_data.rssi_level), 16'(exp.rssi_level));
        check_field("engine_idle", 16'(out_data.engine_idle), 16'(exp.engine_idle));
        check_field("wakeup_seen", 16'(out_data.wakeup_seen), 16'(exp.wakeup_seen));
        check_field("power_on_seen", 16'(out_data.power_on_seen), 16'(exp.power_on_seen));
        check_field("read_data", 16'(out_data.read_data), 16'(exp.read_data));
      end
    end
  end

  // Receiver side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sends one item; valid stays high afterwards until the caller lowers it or
  // the next call replaces the payload.
  task automatic send_item(input fsk_pkg::in_item_t it);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
    items_sent++;
  endtask

  // Lowers valid and waits until every expected result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      fsk_pkg::RegNode:  node_addr = value[4:0];
      fsk_pkg::RegGroup: group_byte = value;
      fsk_pkg::RegFixed: fixed_len = value[6:0];
      default:           rssi_step = value;
    endcase
  endtask

  task automatic set_config(input logic [4:0] nd, input logic [7:0] grp,
                            input logic [6:0] fx, input logic [7:0] st);
    write_reg(fsk_pkg::RegNode, {3'd0, nd});
    write_reg(fsk_pkg::RegGroup, grp);
    write_reg(fsk_pkg::RegFixed, {1'b0, fx});
    write_reg(fsk_pkg::RegStep, st);
  endtask

  function automatic fsk_pkg::in_item_t make_item(input logic [2:0] cmd);
    fsk_pkg::in_item_t it;
    it = '0;
    it.command = cmd;
    return it;
  endfunction

  task automatic radio_event(input logic [7:0] b, input bit above);
    fsk_pkg::in_item_t it;
    it = make_item(fsk_pkg::CmdEvent);
    it.fifo_ready = 1'b1;
    it.data_byte = b;
    it.signal_above = above;
    send_item(it);
  endtask

  task automatic load_byte(input logic [6:0] idx, input logic [7:0] b);
    fsk_pkg::in_item_t it;
    it = make_item(fsk_pkg::CmdLoad);
    it.buffer_index = idx;
    it.data_byte = b;
    send_item(it);
  endtask

  // A read is only issued for entries that hold a known value or lie beyond the buffer.
  task automatic read_byte(input logic [6:0] idx);
    fsk_pkg::in_item_t it;
    it = make_item(fsk_pkg::CmdRead);
    if (idx < BufSize && !buf_written[idx]) idx = 7'($urandom_range(BufSize, 127));
    it.buffer_index = idx;
    send_item(it);
  endtask

  // Loads the payload area that the send will use, then clocks the whole frame out.
  task automatic send_packet(input logic [7:0] hdr, input logic [6:0] plen);
    fsk_pkg::in_item_t it;
    for (int i = 0; i < sat_len(plen); i++)
      if (!buf_written[i + 3] || $urandom_range(3) == 0) load_byte(7'(i), 8'($urandom));
    it = make_item(fsk_pkg::CmdSend);
    it.header = hdr;
    it.payload_length = plen;
    it.data_byte = 8'($urandom);
    send_item(it);
    while (phase != PhIdle) radio_event(8'($urandom), 1'($urandom_range(1)));
  endtask

  // Starts a receive and feeds a frame whose CRC closes unless it is corrupted.
  task automatic recv_packet(input logic [7:0] hdr, input logic [7:0] plen,
                             input bit corrupt);
    logic [7:0] bytes [$];
    logic [15:0] c;
    int pos;
    send_item(make_item(fsk_pkg::CmdRecv));
    if (group_byte == 0) bytes.push_back(8'($urandom));
    bytes.push_back(hdr);
    bytes.push_back(plen);
    for (int i = 0; i < plen && i < 80; i++) bytes.push_back(8'($urandom));
    c = (group_byte != 0) ? crc16_byte(16'hFFFF, group_byte) : 16'hFFFF;
    foreach (bytes[i]) c = crc16_byte(c, bytes[i]);
    bytes.push_back(c[7:0]);
    bytes.push_back(c[15:8]);
    if (corrupt) begin
      pos = $urandom_range(bytes.size() - 1);
      bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(7));
    end
    pos = 0;
    while (phase == PhRecv) begin
      radio_event((pos < bytes.size()) ? bytes[pos] : 8'($urandom),
                  1'($urandom_range(1)));
      pos++;
    end
  endtask

  task automatic noise_item();
    fsk_pkg::in_item_t it;
    it = make_item(3'($urandom_range(7)));
    if (it.command == fsk_pkg::CmdSend) it.command = fsk_pkg::CmdEvent;
    it.fifo_ready = 1'($urandom_range(1));
    it.power_on_reset = ($urandom_range(19) == 0);
    it.wakeup_fired = ($urandom_range(9) == 0);
    it.fifo_overflow = ($urandom_range(19) == 0);
    it.signal_above = 1'($urandom_range(1));
    it.data_byte = 8'($urandom);
    it.header = 8'($urandom);
    it.payload_length = 7'($urandom);
    if (it.command == fsk_pkg::CmdRead) read_byte(7'($urandom_range(127)));
    else begin
      it.buffer_index = 7'($urandom);
      send_item(it);
    end
  endtask

  // Status bits, the idle filler, unused commands, and reads and loads past the buffer.
  task automatic test_status_and_commands();
    fsk_pkg::in_item_t it;
    radio_event(8'h00, 1'b0);
    it = make_item(fsk_pkg::CmdEvent);
    it.power_on_reset = 1'b1;
    send_item(it);
    it = make_item(fsk_pkg::CmdEvent);
    it.wakeup_fired = 1'b1;
    send_item(it);
    it = make_item(fsk_pkg::CmdEvent);
    it.fifo_overflow = 1'b1;
    send_item(it);
    send_item(make_item(3'd5));
    send_item(make_item(3'd6));
    send_item(make_item(3'd7));
    read_byte(7'd127);
    load_byte(7'd127, 8'hFF);
    drain();
  endtask

  // Sends at empty and short payloads, with and without address bits, and
  // checks that an oversized payload length saturates.
  task automatic test_send();
    fsk_pkg::in_item_t it;
    set_config(5'd31, 8'hFF, 7'd0, 8'd1);
    send_packet(8'h00, 7'd0);
    send_packet(8'hFF, 7'd3);
    read_byte(7'd1);
    read_byte(7'd2);
    set_config(5'd10, 8'd0, 7'd0, 8'd255);
    it = make_item(fsk_pkg::CmdSend);
    it.header = 8'h9F;
    it.payload_length = 7'd127;
    send_item(it);
    read_byte(7'd1);
    read_byte(7'd2);
    it = make_item(fsk_pkg::CmdEvent);
    it.power_on_reset = 1'b1;
    send_item(it);
    read_byte(7'd70);
    drain();
  endtask

  // Receives with good and bad CRC, bad length, fixed length and address checks.
  task automatic test_receive();
    set_config(5'd5, 8'd212, 7'd0, 8'd0);
    recv_packet(8'h45, 8'd2, 1'b0);
    recv_packet(8'h46, 8'd2, 1'b0);
    recv_packet(8'h05, 8'd1, 1'b1);
    recv_packet(8'h00, 8'd200, 1'b0);
    read_byte(7'd0);
    set_config(5'd0, 8'd0, 7'd12, 8'd2);
    recv_packet(8'h40, 8'd3, 1'b0);
    set_config(5'd31, 8'd1, 7'd1, 8'd7);
    recv_packet(8'h7F, 8'd0, 1'b0);
    write_reg(fsk_pkg::RegFixed, 8'd0);
    recv_packet(8'h5F, 8'd0, 1'b0);
    drain();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_req = 400;
    for (int i = 0; i < 24; i++) radio_event(8'($urandom), 1'b0);
    drain();
  endtask

  task automatic random_phase(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(9) == 0)
        set_config(5'($urandom_range(31)), ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom),
                   ($urandom_range(9) < 7) ? 7'd0 : 7'($urandom_range(1, 71)),
                   8'(($urandom_range(1) == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(1, 255)));
      case ($urandom_range(9))
        0, 1, 2, 3: recv_packet(8'($urandom),
                                8'(($urandom_range(15) == 0) ? $urandom : $urandom_range(6)),
                                $urandom_range(3) == 0);
        4, 5, 6: send_packet(8'($urandom),
                             7'(($urandom_range(19) == 0) ? $urandom : $urandom_range(6)));
        default: for (int i = 0; i < 4; i++) noise_item();
      endcase
    end
  endtask

  task automatic test_random();
    tx_idle_pct = 12;
    rx_idle_pct = 49;
    random_phase(25);
    tx_idle_pct = 49;
    rx_idle_pct = 12;
    random_phase(25);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(25);
  endtask

  initial begin
    for (int i = 0; i < BufSize; i++) begin
      pkt_buf[i] = 8'h00;
      buf_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_status_and_commands();
    test_send();
    test_receive();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fsk_pkg.sv
rtl/fsk_ram.sv
rtl/fsk_front.sv
rtl/fsk_back.sv
rtl/fsk_radio_packet_engine.sv
sim/testbench.sv
